// ===== sv/rfrp_pkg.sv =====
// types, codes and helpers shared by the rangefinder response parser
package rfrp_pkg;

   localparam int FRAME_BYTES_MAX_DEFAULT = 32;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd0;
   localparam logic [7:0]  START_BYTE_RESET     = 8'd170;
   localparam logic [7:0]  END_BYTE_RESET       = 8'd168;
   localparam logic [15:0] TIMEOUT_MS_RESET     = 16'd1000;

   localparam logic [7:0]  ACK_PAYLOAD   = 8'h01;
   localparam logic [7:0]  CHECKSUM_MASK = 8'h7F;
   localparam logic [30:0] DIST_MAX      = 31'h7FFF_FFFF;
   localparam logic [7:0]  ASCII_ZERO    = 8'h30;
   localparam logic [7:0]  ASCII_NINE    = 8'h39;

   localparam logic [47:0] TEXT_BRIGHT = "ERR256";
   localparam logic [47:0] TEXT_DIM    = "ERR255";
   localparam logic [47:0] TEXT_BAD    = "ERR204";

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_TIMEOUT = 3'd1,
      ST_FAILED  = 3'd2,
      ST_DIM     = 3'd3,
      ST_BRIGHT  = 3'd4,
      ST_BAD     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_START_BYTE     = 2'd1,
      CSR_END_BYTE       = 2'd2,
      CSR_TIMEOUT_MS     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_HUNT    = 3'b010,
      PH_COLLECT = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
      logic [7:0] expected_command;
      logic       expect_ack;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [30:0] distance_mm;
   } rsp_type;

   // character at position pos of a six-letter string, first letter in the top byte
   function automatic logic [7:0] text_char(input logic [47:0] txt, input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = txt[47:40];
         3'd1: ch = txt[39:32];
         3'd2: ch = txt[31:24];
         3'd3: ch = txt[23:16];
         3'd4: ch = txt[15:8];
         3'd5: ch = txt[7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== sv/rangefinder_response_parser.sv =====
// rangefinder reply parser: frame hunt, collection, checks and distance decode
// a result passes the input register holding the byte or tick that completes it,
//    then is loaded into the result register together with the state update
// throughput: one transaction per cycle, limited only by the result register draining
// reset: synchronous, returns to idle and loads the register defaults
module rangefinder_response_parser #(
   parameter int FRAME_BYTES_MAX = rfrp_pkg::FRAME_BYTES_MAX_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rfrp_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rfrp_pkg::rsp_type       rsp_data,
   input  logic                    csr_we,
   input  rfrp_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);

   localparam int LenBits  = $clog2(FRAME_BYTES_MAX + 1);
   localparam int LenWidth = (LenBits > 4) ? LenBits : 4;

   logic [7:0]  device_address_ff, device_address_in;
   logic [7:0]  start_byte_ff, start_byte_in;
   logic [7:0]  end_byte_ff, end_byte_in;
   logic [15:0] timeout_ms_ff, timeout_ms_in;

   logic              item_valid_ff, item_valid_in;
   rfrp_pkg::req_type item_ff, item_in;

   rfrp_pkg::phase_type phase_ff, phase_in;
   logic [LenWidth-1:0] len_ff, len_in;
   logic [15:0]         elapsed_ff, elapsed_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          lag_ff, lag_in;
   logic [7:0]          addr_ff, addr_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [7:0]          first_ff, first_in;
   logic [30:0]         digit_ff, digit_in;
   logic                nondigit_ff, nondigit_in;
   logic [2:0]          match_ff, match_in;
   logic [7:0]          wanted_ff, wanted_in;
   logic                ack_ff, ack_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rfrp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                advance;
   logic                res_valid;
   rfrp_pkg::rsp_type   res;
   rfrp_pkg::rsp_type   finish;
   logic [7:0]          chk;
   logic                frame_bad;
   logic [LenWidth-1:0] pos;
   logic [34:0]         digit_sum;
   logic [7:0]          digit;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration
   always_comb begin
      device_address_in = device_address_ff;
      start_byte_in     = start_byte_ff;
      end_byte_in       = end_byte_ff;
      timeout_ms_in     = timeout_ms_ff;
      if (csr_we) begin
         case (csr_index)
            rfrp_pkg::CSR_DEVICE_ADDRESS: device_address_in = csr_wdata[7:0];
            rfrp_pkg::CSR_START_BYTE:     start_byte_in     = csr_wdata[7:0];
            rfrp_pkg::CSR_END_BYTE:       end_byte_in       = csr_wdata[7:0];
            rfrp_pkg::CSR_TIMEOUT_MS:     timeout_ms_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   // frame checks on end byte, len_ff holds the index of the end byte
   always_comb begin
      chk       = (sum_ff - lag_ff) & rfrp_pkg::CHECKSUM_MASK;
      frame_bad = (len_ff < LenWidth'(4)) || (lag_ff != chk) || (cmd_ff != wanted_ff)
                  || (addr_ff != device_address_ff);
      finish.status      = rfrp_pkg::ST_OK;
      finish.distance_mm = '0;
      if (frame_bad) begin
         finish.status = rfrp_pkg::ST_FAILED;
      end else if (ack_ff) begin
         if ((len_ff == LenWidth'(4)) || (first_ff != rfrp_pkg::ACK_PAYLOAD)) begin
            finish.status = rfrp_pkg::ST_FAILED;
         end
      end else if ((len_ff == LenWidth'(10)) && match_ff[0]) begin
         finish.status = rfrp_pkg::ST_BRIGHT;
      end else if ((len_ff == LenWidth'(10)) && match_ff[1]) begin
         finish.status = rfrp_pkg::ST_DIM;
      end else if ((len_ff == LenWidth'(10)) && match_ff[2]) begin
         finish.status = rfrp_pkg::ST_BAD;
      end else if (nondigit_ff) begin
         finish.status = rfrp_pkg::ST_FAILED;
      end else begin
         finish.distance_mm = digit_ff;
      end
   end

   // payload byte trails the received byte by one so the checksum stays out
   assign pos       = len_ff - LenWidth'(4);
   assign digit     = lag_ff - rfrp_pkg::ASCII_ZERO;
   assign digit_sum = {1'b0, digit_ff, 3'b000} + {3'b000, digit_ff, 1'b0}
                      + {31'd0, digit[3:0]};

   // state update
   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      elapsed_in  = elapsed_ff;
      sum_in      = sum_ff;
      lag_in      = lag_ff;
      addr_in     = addr_ff;
      cmd_in      = cmd_ff;
      first_in    = first_ff;
      digit_in    = digit_ff;
      nondigit_in = nondigit_ff;
      match_in    = match_ff;
      wanted_in   = wanted_ff;
      ack_in      = ack_ff;
      res_valid   = 1'b0;
      res.status      = rfrp_pkg::ST_OK;
      res.distance_mm = '0;
      if (advance) begin
         case (item_ff.operation)
            rfrp_pkg::OP_START: begin
               phase_in    = rfrp_pkg::PH_HUNT;
               len_in      = '0;
               elapsed_in  = '0;
               sum_in      = '0;
               lag_in      = '0;
               addr_in     = '0;
               cmd_in      = '0;
               first_in    = '0;
               digit_in    = '0;
               nondigit_in = 1'b0;
               match_in    = 3'b111;
               wanted_in   = item_ff.expected_command;
               ack_in      = item_ff.expect_ack;
            end
            rfrp_pkg::OP_BYTE: begin
               if (phase_ff == rfrp_pkg::PH_HUNT) begin
                  if (item_ff.rx_byte == start_byte_ff) begin
                     len_in   = LenWidth'(1);
                     phase_in = rfrp_pkg::PH_COLLECT;
                  end
               end else if (phase_ff == rfrp_pkg::PH_COLLECT) begin
                  len_in = len_ff + LenWidth'(1);
                  if (item_ff.rx_byte == end_byte_ff) begin
                     res_valid = 1'b1;
                     res       = finish;
                     phase_in  = rfrp_pkg::PH_IDLE;
                  end else begin
                     if (len_ff >= LenWidth'(4)) begin
                        if (len_ff == LenWidth'(4)) begin
                           first_in = lag_ff;
                        end
                        if (len_ff < LenWidth'(10)) begin
                           if (lag_ff != rfrp_pkg::text_char(rfrp_pkg::TEXT_BRIGHT, pos[2:0]))
                              match_in[0] = 1'b0;
                           if (lag_ff != rfrp_pkg::text_char(rfrp_pkg::TEXT_DIM, pos[2:0]))
                              match_in[1] = 1'b0;
                           if (lag_ff != rfrp_pkg::text_char(rfrp_pkg::TEXT_BAD, pos[2:0]))
                              match_in[2] = 1'b0;
                        end
                        if ((lag_ff < rfrp_pkg::ASCII_ZERO) || (lag_ff > rfrp_pkg::ASCII_NINE)) begin
                           nondigit_in = 1'b1;
                        end else if (|digit_sum[34:31]) begin
                           digit_in = rfrp_pkg::DIST_MAX;
                        end else begin
                           digit_in = digit_sum[30:0];
                        end
                     end
                     if (len_ff == LenWidth'(1)) addr_in = item_ff.rx_byte;
                     if (len_ff == LenWidth'(2)) cmd_in = item_ff.rx_byte;
                     sum_in = sum_ff + item_ff.rx_byte;
                     lag_in = item_ff.rx_byte;
                     // buffer full without an end byte
                     if (len_in == LenWidth'(FRAME_BYTES_MAX)) begin
                        res_valid  = 1'b1;
                        res.status = rfrp_pkg::ST_TIMEOUT;
                        phase_in   = rfrp_pkg::PH_IDLE;
                     end
                  end
               end
            end
            rfrp_pkg::OP_TICK: begin
               if (phase_ff != rfrp_pkg::PH_IDLE) begin
                  if (elapsed_ff >= timeout_ms_ff) begin
                     res_valid  = 1'b1;
                     res.status = rfrp_pkg::ST_TIMEOUT;
                     phase_in   = rfrp_pkg::PH_IDLE;
                  end else begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= rfrp_pkg::DEVICE_ADDRESS_RESET;
         start_byte_ff     <= rfrp_pkg::START_BYTE_RESET;
         end_byte_ff       <= rfrp_pkg::END_BYTE_RESET;
         timeout_ms_ff     <= rfrp_pkg::TIMEOUT_MS_RESET;
         item_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         phase_ff          <= rfrp_pkg::PH_IDLE;
      end else begin
         device_address_ff <= device_address_in;
         start_byte_ff     <= start_byte_in;
         end_byte_ff       <= end_byte_in;
         timeout_ms_ff     <= timeout_ms_in;
         item_valid_ff     <= item_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         phase_ff          <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
      len_ff      <= len_in;
      elapsed_ff  <= elapsed_in;
      sum_ff      <= sum_in;
      lag_ff      <= lag_in;
      addr_ff     <= addr_in;
      cmd_ff      <= cmd_in;
      first_ff    <= first_in;
      digit_ff    <= digit_in;
      nondigit_ff <= nondigit_in;
      match_ff    <= match_in;
      wanted_ff   <= wanted_in;
      ack_ff      <= ack_in;
   end

   // a reported transaction always leaves the parser idle
   assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |=> (phase_ff == rfrp_pkg::PH_IDLE))
      else $error("parser not idle after result");

   // the start byte search only runs with an empty frame
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rfrp_pkg::PH_HUNT) |-> (len_ff == '0))
      else $error("frame length nonzero while hunting");

   // a distance is only reported with ok status in measurement mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.distance_mm != '0))
         |-> (rsp_data_ff.status == rfrp_pkg::ST_OK))
      else $error("distance reported with error status");

   // no new result is loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("result register overwritten");

endmodule
